// File: rtl/srlp_pkg.sv
// srlp_pkg: shared types and constants for the SMTP reply line parser.
// No dependencies; used by smtp_reply_line_parser and its checker.
`default_nettype none

package srlp_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned KindW   = 3;
   localparam int unsigned CodeW   = 10;
   localparam int unsigned ErrW    = 3;
   localparam int unsigned CountW  = 2;

   localparam logic [KindW-1:0] KIND_NONE      = 3'd0;
   localparam logic [KindW-1:0] KIND_TEXT      = 3'd1;
   localparam logic [KindW-1:0] KIND_CONT_END  = 3'd2;
   localparam logic [KindW-1:0] KIND_REPLY_END = 3'd3;
   localparam logic [KindW-1:0] KIND_ERROR     = 3'd4;

   localparam logic [ErrW-1:0] ERR_NONE     = 3'd0;
   localparam logic [ErrW-1:0] ERR_SHORT    = 3'd1;
   localparam logic [ErrW-1:0] ERR_LONG     = 3'd2;
   localparam logic [ErrW-1:0] ERR_NONDIGIT = 3'd3;
   localparam logic [ErrW-1:0] ERR_MISMATCH = 3'd4;
   localparam logic [ErrW-1:0] ERR_NO_LF    = 3'd5;

   localparam logic [ByteW-1:0] CH_ZERO   = 8'h30;
   localparam logic [ByteW-1:0] CH_NINE   = 8'h39;
   localparam logic [ByteW-1:0] CH_HYPHEN = 8'h2D;
   localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
   localparam logic [ByteW-1:0] CH_CR     = 8'h0D;
   localparam logic [ByteW-1:0] CH_LF     = 8'h0A;

   localparam logic [CountW-1:0] CODE_DIGITS = 2'd3;

   typedef enum logic [2:0] {
      PH_CODE = 3'b001,
      PH_TEXT = 3'b010,
      PH_LF   = 3'b100
   } phase_type;

endpackage

`default_nettype wire

// File: rtl/smtp_reply_line_parser.sv
// smtp_reply_line_parser: top level, byte-wide SMTP reply line parser.
// Depends on srlp_pkg.
//
// Usage: the server-to-client byte stream enters on the req_ channel, one
// byte per beat. Every accepted byte yields exactly one beat on the rsp_
// channel: kind none, a text byte, a line end with its status code
// (continued line or end of reply), or an error with its error code.
// After the first error every later byte yields kind none until reset.
// The result is registered: a byte accepted in one cycle shows its result
// in the next. Throughput is one byte per cycle when not stalled; the parse
// state and result register are updated together at each accepted beat.
// When the receiver stalls, the result register holds its beat and
// req_stall rises in the same cycle; a waiting result is taken and a new
// byte accepted in the same cycle as soon as rsp_stall drops.
// Reset (synchronous) empties the result register and returns the parser
// to the start of a reply, clearing any earlier error.
`default_nettype none

module smtp_reply_line_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_byte_in,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [2:0] rsp_kind,
   output      logic [7:0] rsp_text_byte,
   output      logic [9:0] rsp_status_code,
   output      logic [2:0] rsp_error_code
);

   srlp_pkg::phase_type phase_ff, phase_in;
   logic [1:0] digit_count_ff, digit_count_in;
   logic [9:0] code_accum_ff, code_accum_in;
   logic       continues_ff, continues_in;
   logic       first_line_ff, first_line_in;
   logic [9:0] reply_code_ff, reply_code_in;
   logic       failed_ff, failed_in;

   logic       rsp_valid_ff;
   logic [2:0] kind_ff, kind_in;
   logic [7:0] text_ff, text_in;
   logic [9:0] status_ff, status_in;
   logic [2:0] err_ff, err_in;

   logic        accept;
   logic        is_sep;
   logic        is_digit;
   logic [13:0] times_ten;
   logic [9:0]  digit_val;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_sep    = (req_byte_in == srlp_pkg::CH_SPACE) || (req_byte_in == srlp_pkg::CH_HYPHEN);
   assign is_digit  = (req_byte_in >= srlp_pkg::CH_ZERO) && (req_byte_in <= srlp_pkg::CH_NINE);
   assign times_ten = 14'(code_accum_ff) * 14'd10;
   assign digit_val = 10'(req_byte_in - srlp_pkg::CH_ZERO);

   always_comb begin
      phase_in       = phase_ff;
      digit_count_in = digit_count_ff;
      code_accum_in  = code_accum_ff;
      continues_in   = continues_ff;
      first_line_in  = first_line_ff;
      reply_code_in  = reply_code_ff;
      failed_in      = failed_ff;
      kind_in        = srlp_pkg::KIND_NONE;
      text_in        = '0;
      status_in      = '0;
      err_in         = srlp_pkg::ERR_NONE;

      if (!failed_ff) begin
         case (phase_ff)
            srlp_pkg::PH_TEXT: begin
               if (req_byte_in == srlp_pkg::CH_CR) begin
                  phase_in = srlp_pkg::PH_LF;
               end else begin
                  kind_in = srlp_pkg::KIND_TEXT;
                  text_in = req_byte_in;
               end
            end
            srlp_pkg::PH_LF: begin
               if (req_byte_in != srlp_pkg::CH_LF) begin
                  failed_in = 1'b1;
                  kind_in   = srlp_pkg::KIND_ERROR;
                  err_in    = srlp_pkg::ERR_NO_LF;
               end else if (!first_line_ff && (code_accum_ff != reply_code_ff)) begin
                  failed_in = 1'b1;
                  kind_in   = srlp_pkg::KIND_ERROR;
                  err_in    = srlp_pkg::ERR_MISMATCH;
               end else begin
                  if (first_line_ff) begin
                     reply_code_in = code_accum_ff;
                  end
                  // a final line re-arms the first-line capture
                  first_line_in  = !continues_ff;
                  kind_in        = continues_ff ? srlp_pkg::KIND_CONT_END
                                                : srlp_pkg::KIND_REPLY_END;
                  status_in      = code_accum_ff;
                  code_accum_in  = '0;
                  digit_count_in = '0;
                  phase_in       = srlp_pkg::PH_CODE;
               end
            end
            default: begin
               if (is_sep) begin
                  if (digit_count_ff != srlp_pkg::CODE_DIGITS) begin
                     failed_in = 1'b1;
                     kind_in   = srlp_pkg::KIND_ERROR;
                     err_in    = srlp_pkg::ERR_SHORT;
                  end else begin
                     continues_in = (req_byte_in == srlp_pkg::CH_HYPHEN);
                     phase_in     = srlp_pkg::PH_TEXT;
                  end
               end else if (digit_count_ff == srlp_pkg::CODE_DIGITS) begin
                  failed_in = 1'b1;
                  kind_in   = srlp_pkg::KIND_ERROR;
                  err_in    = srlp_pkg::ERR_LONG;
               end else if (!is_digit) begin
                  failed_in = 1'b1;
                  kind_in   = srlp_pkg::KIND_ERROR;
                  err_in    = srlp_pkg::ERR_NONDIGIT;
               end else begin
                  code_accum_in  = times_ten[9:0] + digit_val;
                  digit_count_in = digit_count_ff + 2'd1;
                  phase_in       = srlp_pkg::PH_CODE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= srlp_pkg::PH_CODE;
         digit_count_ff <= '0;
         code_accum_ff  <= '0;
         continues_ff   <= 1'b0;
         first_line_ff  <= 1'b1;
         reply_code_ff  <= '0;
         failed_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            digit_count_ff <= digit_count_in;
            code_accum_ff  <= code_accum_in;
            continues_ff   <= continues_in;
            first_line_ff  <= first_line_in;
            reply_code_ff  <= reply_code_in;
            failed_ff      <= failed_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= kind_in;
         text_ff   <= text_in;
         status_ff <= status_in;
         err_ff    <= err_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_text_byte   = text_ff;
   assign rsp_status_code = status_ff;
   assign rsp_error_code  = err_ff;

endmodule

`default_nettype wire

// File: rtl/srlp_checker.sv
// srlp_checker: port-level assertions for smtp_reply_line_parser, and its bind.
// Depends on srlp_pkg and smtp_reply_line_parser.
`default_nettype none

module srlp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [2:0] rsp_kind,
   input wire logic [7:0] rsp_text_byte,
   input wire logic [9:0] rsp_status_code,
   input wire logic [2:0] rsp_error_code
);

   // result register empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // a stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_text_byte)
         && $stable(rsp_status_code) && $stable(rsp_error_code))
      else $error("stalled result beat changed");

   // every accepted byte yields a beat on the next cycle
   a_one_per_byte: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted byte gave no result beat");

   // fields not belonging to the kind read as zero
   a_fields_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == srlp_pkg::KIND_TEXT) || (rsp_text_byte == 8'd0))
         && ((rsp_kind == srlp_pkg::KIND_ERROR) || (rsp_error_code == srlp_pkg::ERR_NONE))
         && ((rsp_kind == srlp_pkg::KIND_CONT_END) || (rsp_kind == srlp_pkg::KIND_REPLY_END)
             || (rsp_status_code == 10'd0)))
      else $error("result field set for wrong kind");

   // a line end carries a three-digit code
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == srlp_pkg::KIND_CONT_END)
         || (rsp_kind == srlp_pkg::KIND_REPLY_END)) |-> rsp_status_code <= 10'd999)
      else $error("status code out of range");

endmodule

bind smtp_reply_line_parser srlp_checker u_srlp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_text_byte   (rsp_text_byte),
   .rsp_status_code (rsp_status_code),
   .rsp_error_code  (rsp_error_code)
);

`default_nettype wire
